@@ rtl/lged_pkg.sv @@
`default_nettype none

package lged_pkg;

    // Default frame limits handed to the top level.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration port.
    localparam int CFG_DIM_W = 11;
    localparam int CFG_THR_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST    = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST   = 11'd1024;
    localparam logic [CFG_THR_W-1:0] EDGE_THRESHOLD_RST = 8'd30;

    // Pixel word: red in bits 7..0, green 15..8, blue 23..16.
    localparam int PIX_W   = 24;
    localparam int COORD_W = 10;
    localparam logic [PIX_W-1:0] WHITE_PIX = 24'hFF_FFFF;
    localparam logic [PIX_W-1:0] BLACK_PIX = 24'h00_0000;

    // Stream widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * COORD_W;

    // Luma at a scale of one thousand.
    localparam int LUMA_W     = 18;
    localparam int LUMA_R     = 299;
    localparam int LUMA_G     = 587;
    localparam int LUMA_B     = 114;
    localparam int THR_SCALE  = 1000;

    // Result queue; the depth must be a power of two.
    localparam int OQ_DEPTH = 8;

    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } t_result;

    // Scaled luma of one pixel word.
    function automatic logic [LUMA_W-1:0] luma(input logic [PIX_W-1:0] p);
        return LUMA_W'(p[7:0])   * LUMA_W'(LUMA_R)
             + LUMA_W'(p[15:8])  * LUMA_W'(LUMA_G)
             + LUMA_W'(p[23:16]) * LUMA_W'(LUMA_B);
    endfunction

endpackage

`default_nettype wire

@@ rtl/luma_gradient_edge_detector_unit.sv @@
`default_nettype none

// Luma forward-difference edge detector on a raster RGB pixel stream.
// Slave channel: one pixel per beat, raster order, column fastest.
// Master channel: result pixels with their column and row; tlast marks the
// final result caused by an input beat. A row above yields one result per
// pixel (black for an edge, white for flat, the pixel itself in the last
// column); the last row adds the pixel's own result after it.
// The user must write configuration through the plain write port while idle;
// the block does not enforce it. Results pass stage A, stage B and the queue.
// One pixel is taken per cycle while each beat yields at most one result and the
// receiver keeps up; on the last row the single master channel holds back input.
// The line store is a two-read memory; each pixel reads its own column and
// the one to its right and writes its column in the same cycle.
// Results wait in an eight-entry queue; o_s_tready drops once more than six
// results are queued or in flight, so a stalled receiver holds back the source.
// Reset clears counters, valid bits and configuration and empties the queue; no
// clearing pass is run and the line store holds whatever it held until a row is written.
module luma_gradient_edge_detector_unit #(
    parameter int MAX_WIDTH  = lged_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lged_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lged_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lged_pkg::CFG_DIM_W-1:0]      i_cfg_data,
    // Pixel input.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
    input  wire logic [lged_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // Result output.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: red_out[7:0], green_out[15:8], blue_out[23:16],
    //        pixel_column[33:24], pixel_row[43:34], zeros[47:44]
    output logic      [lged_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // tlast: run_last
    output logic                                     o_m_tlast
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = ($clog2(MAX_WIDTH + 1) > lged_pkg::CFG_DIM_W)
                       ? $clog2(MAX_WIDTH + 1) : lged_pkg::CFG_DIM_W;
    localparam int HDW = ($clog2(MAX_HEIGHT + 1) > lged_pkg::CFG_DIM_W)
                       ? $clog2(MAX_HEIGHT + 1) : lged_pkg::CFG_DIM_W;
    localparam int OQ_AW = $clog2(lged_pkg::OQ_DEPTH);
    localparam int OQ_CW = $clog2(lged_pkg::OQ_DEPTH + 1);
    localparam int PW    = lged_pkg::PIX_W;
    localparam int LW    = lged_pkg::LUMA_W;

    // Configuration registers.
    logic [lged_pkg::CFG_DIM_W-1:0] r_frame_width;
    logic [lged_pkg::CFG_DIM_W-1:0] r_frame_height;
    logic [lged_pkg::CFG_THR_W-1:0] r_edge_threshold;

    // Position of the next incoming pixel.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Stage A: pixel accepted, line store read in flight.
    logic          r_a_valid;
    logic [PW-1:0] r_a_pix;
    logic [CW-1:0] r_a_col;
    logic [RW-1:0] r_a_row;
    logic          r_a_last_col;
    logic          r_a_last_row;
    logic          r_a_has_above;

    // Stage B: lumas registered.
    logic          r_b_valid;
    logic [PW-1:0] r_b_pix;
    logic [PW-1:0] r_b_above;
    logic [LW-1:0] r_b_lc;
    logic [LW-1:0] r_b_lr;
    logic [LW-1:0] r_b_lb;
    logic [CW-1:0] r_b_col;
    logic [RW-1:0] r_b_row;
    logic          r_b_last_col;
    logic          r_b_last_row;
    logic          r_b_has_above;

    // Result queue.
    lged_pkg::t_result r_oq [lged_pkg::OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wp;
    logic [OQ_AW-1:0]  r_rp;
    logic [OQ_CW-1:0]  r_fcount;
    logic [OQ_CW-1:0]  r_used;

    logic [WDW-1:0] col_limit;
    logic [HDW-1:0] row_limit;
    logic           last_col;
    logic           last_row;
    logic           has_above;
    logic           s_fire;
    logic           m_fire;
    logic [OQ_CW-1:0] acc_res;
    logic [OQ_CW-1:0] push_cnt;
    logic [PW-1:0]  ram_rdata0;
    logic [PW-1:0]  ram_rdata1;
    logic [LW-1:0]  thr;
    logic [LW-1:0]  diff_r;
    logic [LW-1:0]  diff_b;
    logic           is_edge;
    lged_pkg::t_result res_above;
    lged_pkg::t_result res_self;
    lged_pkg::t_result head;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= lged_pkg::FRAME_WIDTH_RST;
            r_frame_height   <= lged_pkg::FRAME_HEIGHT_RST;
            r_edge_threshold <= lged_pkg::EDGE_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lged_pkg::REG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data;
                lged_pkg::REG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data;
                lged_pkg::REG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Last column and last row index, with the frame size clamped.
    always_comb begin
        if (WDW'(r_frame_width) == '0) begin
            col_limit = '0;
        end else if (WDW'(r_frame_width) > WDW'(MAX_WIDTH)) begin
            col_limit = WDW'(MAX_WIDTH - 1);
        end else begin
            col_limit = WDW'(r_frame_width) - WDW'(1);
        end
        if (HDW'(r_frame_height) == '0) begin
            row_limit = '0;
        end else if (HDW'(r_frame_height) > HDW'(MAX_HEIGHT)) begin
            row_limit = HDW'(MAX_HEIGHT - 1);
        end else begin
            row_limit = HDW'(r_frame_height) - HDW'(1);
        end
        last_col  = WDW'(r_col) >= col_limit;
        last_row  = HDW'(r_row) >= row_limit;
        has_above = r_row != '0;
    end

    // Handshakes and the number of results an accepted beat will bring.
    assign o_s_tready = r_used <= OQ_CW'(lged_pkg::OQ_DEPTH - 2);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_fcount != '0;
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign acc_res    = OQ_CW'(has_above) + OQ_CW'(last_row);

    // Raster position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_fire) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store: this column and the next are read as the pixel is written.
    lged_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_we     (s_fire),
        .i_waddr  (r_col),
        .i_wdata  (i_s_tdata[PW-1:0]),
        .i_raddr0 (r_col),
        .i_raddr1 (r_col + CW'(1)),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= s_fire;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage A capture.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_pix       <= i_s_tdata[PW-1:0];
            r_a_col       <= r_col;
            r_a_row       <= r_row;
            r_a_last_col  <= last_col;
            r_a_last_row  <= last_row;
            r_a_has_above <= has_above;
        end
    end

    // Stage B: lumas of the pixel above, its right neighbour and the new pixel.
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_pix       <= r_a_pix;
            r_b_above     <= ram_rdata0;
            r_b_lc        <= lged_pkg::luma(ram_rdata0);
            r_b_lr        <= lged_pkg::luma(ram_rdata1);
            r_b_lb        <= lged_pkg::luma(r_a_pix);
            r_b_col       <= r_a_col;
            r_b_row       <= r_a_row;
            r_b_last_col  <= r_a_last_col;
            r_b_last_row  <= r_a_last_row;
            r_b_has_above <= r_a_has_above;
        end
    end

    // Threshold test and the results of one beat.
    always_comb begin
        thr     = LW'(r_edge_threshold) * LW'(lged_pkg::THR_SCALE);
        diff_r  = (r_b_lc > r_b_lr) ? r_b_lc - r_b_lr : r_b_lr - r_b_lc;
        diff_b  = (r_b_lc > r_b_lb) ? r_b_lc - r_b_lb : r_b_lb - r_b_lc;
        is_edge = (diff_r > thr) || (diff_b > thr);

        res_above.pix  = r_b_last_col ? r_b_above
                       : (is_edge ? lged_pkg::BLACK_PIX : lged_pkg::WHITE_PIX);
        res_above.col  = lged_pkg::COORD_W'(r_b_col);
        res_above.row  = lged_pkg::COORD_W'(r_b_row - RW'(1));
        res_above.last = !r_b_last_row;

        res_self.pix   = r_b_last_col ? lged_pkg::WHITE_PIX : r_b_pix;
        res_self.col   = lged_pkg::COORD_W'(r_b_col);
        res_self.row   = lged_pkg::COORD_W'(r_b_row);
        res_self.last  = 1'b1;

        push_cnt = r_b_valid ? OQ_CW'(r_b_has_above) + OQ_CW'(r_b_last_row) : '0;
    end

    // Queue storage: up to two entries written per cycle.
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            if (r_b_has_above) begin
                r_oq[r_wp] <= res_above;
            end
            if (r_b_last_row) begin
                r_oq[r_b_has_above ? r_wp + OQ_AW'(1) : r_wp] <= res_self;
            end
        end
    end

    // Queue pointers and counts; r_used also counts results still in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_fcount <= '0;
            r_used   <= '0;
        end else begin
            r_wp     <= r_wp + OQ_AW'(push_cnt);
            r_rp     <= r_rp + OQ_AW'(m_fire);
            r_fcount <= r_fcount + push_cnt - OQ_CW'(m_fire);
            r_used   <= r_used + (s_fire ? acc_res : '0) - OQ_CW'(m_fire);
        end
    end

    // Head of the queue drives the master channel.
    assign head      = r_oq[r_rp];
    assign o_m_tdata = {lged_pkg::OUT_PAD_W'(0), head.row, head.col, head.pix};
    assign o_m_tlast = head.last;

endmodule

`default_nettype wire

@@ rtl/lged_ram.sv @@
`default_nettype none

// Simple memory: one write port, two registered read ports, read-first.
module lged_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read of the entry being written returns its old contents.
    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lged_checker.sv @@
`default_nettype none

// Port-level checks for the edge detector.
module lged_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_s_tready,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [lged_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                             o_m_tlast
);

    // A result offered to a stalled receiver is still offered next cycle.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat withdrawn while stalled");

    // Reset empties the queue and reopens the input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("queue not empty or input closed after reset");

    // A beat that is not the last of its run is followed at once by its partner.
    a_pair_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("second result of a last-row pixel missing");

    // The partner describes the same column, one row further down.
    a_pair_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tdata[33:24] == $past(o_m_tdata[33:24]) &&
            o_m_tdata[43:34] == $past(o_m_tdata[43:34]) + 10'd1 && o_m_tlast)
        else $error("last-row result pair has wrong coordinates");

endmodule

bind luma_gradient_edge_detector_unit lged_checker u_lged_checker (.*);

`default_nettype wire
